FILE: src/rsp_pkg.sv
// Shared types and constants for the response framer.
package rsp_pkg;

  // Framing characters
  localparam logic [7:0] CHAR_ACK    = 8'h2b;  // '+'
  localparam logic [7:0] CHAR_START  = 8'h24;  // '$'
  localparam logic [7:0] CHAR_END    = 8'h23;  // '#'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_A_LOW  = 8'h61;  // 'a'

  // Positions in the per-item slot mask, in emit order
  localparam int SLOT_ACK   = 0;
  localparam int SLOT_START = 1;
  localparam int SLOT_DATA  = 2;
  localparam int SLOT_END   = 3;
  localparam int SLOT_HI    = 4;
  localparam int SLOT_LO    = 5;
  localparam int NUM_SLOTS  = 6;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // Lowercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] res;
    if (nibble < 4'd10) begin
      res = CHAR_ZERO + {4'd0, nibble};
    end else begin
      res = CHAR_A_LOW + {4'd0, nibble} - 8'd10;
    end
    return res;
  endfunction

endpackage

FILE: src/rsp_item_if.sv
// Payload item channel into the response framer.
interface rsp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       first_item;
  logic       last_item;
  logic       add_start;
  logic       add_end;

  modport source (output valid, payload_byte, has_byte, first_item, last_item,
                  add_start, add_end, input ready);
  modport sink   (input valid, payload_byte, has_byte, first_item, last_item,
                  add_start, add_end, output ready);
endinterface

FILE: src/rsp_byte_if.sv
// Framed byte channel out of the response framer.
interface rsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  logic       end_of_packet;

  modport source (output valid, out_byte, end_of_run, end_of_packet, input ready);
  modport sink   (input valid, out_byte, end_of_run, end_of_packet, output ready);
endinterface

FILE: src/rsp_response_framer.sv
// Top level of the debugger protocol response framer.
//
// Takes payload items on the item channel and sends the framed byte stream
// on the framed channel, one byte per beat. An item with first_item and
// add_start yields '+' (left out when skip_ack is set) and '$'; an item
// with has_byte passes its byte and adds it to the 8-bit checksum; an item
// with last_item and add_end yields '#' and two lowercase hex digits of the
// checksum. end_of_run marks an item's last byte, end_of_packet the last
// byte of an item with last_item. Items that produce nothing are dropped.
// An item is registered in the held item stage at its beat, and its bytes
// then pass one at a time through the single output byte register (one
// byte for a plain payload item, up to six for a fully framed one-byte
// packet). A held item is released in the same cycle its last byte moves
// to the output register, so back-to-back payload items flow at one per
// cycle while the receiver does not stall.
// Reset clears the checksum, skip_ack and both valid flags. When the
// receiver stalls, the output byte holds and the item stage fills and
// then drops ready.
module rsp_response_framer
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rsp_item_if.sink    item,
  rsp_byte_if.source  framed
);

  // Configuration and checksum state
  logic       skip_ack;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;

  // Held item stage
  logic       held_valid;
  slot_mask_t held_mask;
  slot_mask_t held_rest;
  logic [7:0] held_byte;
  logic [7:0] held_sum;
  logic       held_last;

  // Output byte register
  logic       out_valid;
  logic [7:0] out_data;
  logic       out_eor;
  logic       out_eop;

  logic       item_beat;
  logic       emit;
  logic       held_done;
  slot_mask_t new_mask;
  logic [7:0] emit_byte;

  assign item_beat = item.valid && item.ready;

  // Checksum after this item's byte
  always_comb begin
    running_sum_next = item.first_item ? 8'd0 : running_sum;
    if (item.has_byte) begin
      running_sum_next = running_sum_next + item.payload_byte;
    end
  end

  // Which bytes this item produces
  always_comb begin
    new_mask             = '0;
    new_mask[SLOT_ACK]   = item.first_item && item.add_start && !skip_ack;
    new_mask[SLOT_START] = item.first_item && item.add_start;
    new_mask[SLOT_DATA]  = item.has_byte;
    new_mask[SLOT_END]   = item.last_item && item.add_end;
    new_mask[SLOT_HI]    = item.last_item && item.add_end;
    new_mask[SLOT_LO]    = item.last_item && item.add_end;
  end

  // Byte for the lowest pending slot
  always_comb begin
    priority if (held_mask[SLOT_ACK]) begin
      emit_byte = CHAR_ACK;
    end else if (held_mask[SLOT_START]) begin
      emit_byte = CHAR_START;
    end else if (held_mask[SLOT_DATA]) begin
      emit_byte = held_byte;
    end else if (held_mask[SLOT_END]) begin
      emit_byte = CHAR_END;
    end else if (held_mask[SLOT_HI]) begin
      emit_byte = hex_char(held_sum[7:4]);
    end else begin
      emit_byte = hex_char(held_sum[3:0]);
    end
  end

  assign held_rest  = held_mask & (held_mask - slot_mask_t'(1));
  assign emit       = held_valid && (!out_valid || framed.ready);
  assign held_done  = emit && (held_rest == '0);
  assign item.ready = !held_valid || held_done;

  // Config register and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_ack    <= 1'b0;
      running_sum <= 8'd0;
    end else begin
      if (cfg_we) begin
        skip_ack <= cfg_wdata;
      end
      if (item_beat) begin
        running_sum <= running_sum_next;
      end
    end
  end

  // Held item stage
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_mask  <= '0;
    end else if (item_beat) begin
      held_valid <= (new_mask != '0);
      held_mask  <= new_mask;
    end else if (emit) begin
      held_mask <= held_rest;
      if (held_rest == '0) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_beat) begin
      held_byte <= item.payload_byte;
      held_sum  <= running_sum_next;
      held_last <= item.last_item;
    end
  end

  // Output byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (framed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_byte;
      out_eor  <= (held_rest == '0);
      out_eop  <= (held_rest == '0) && held_last;
    end
  end

  assign framed.valid         = out_valid;
  assign framed.out_byte      = out_data;
  assign framed.end_of_run    = out_eor;
  assign framed.end_of_packet = out_eop;

endmodule

FILE: verif/rsp_response_framer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the response framer, checked beat by beat.
module rsp_response_framer_test
  import rsp_pkg::*;
();

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       first_item;
    logic       last_item;
    logic       add_start;
    logic       add_end;
  } payload_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_packet;
  } framed_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  rsp_item_if item_ch ();
  rsp_byte_if byte_ch ();

  rsp_response_framer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .framed    (byte_ch)
  );

  // Predictor state: shadow of the register and the packet checksum
  logic         ack_off;
  logic [7:0]   pkt_sum;
  framed_beat_t pending_beats[$];
  int           framed_items;
  int           errors;
  bit           idle_on;

  always #6 clk = ~clk;

  // Lowercase ASCII hex digit of a nibble
  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + 8'(nib);
    end
    return CHAR_A_LOW + 8'(nib) - 8'd10;
  endfunction

  // Work out the framed bytes one item causes; returns how many
  function automatic int frame_item(input payload_item_t it);
    logic [7:0]   bytes_out[$];
    framed_beat_t bt;
    if (it.first_item) begin
      pkt_sum = 8'd0;
      if (it.add_start) begin
        if (!ack_off) bytes_out.push_back(CHAR_ACK);
        bytes_out.push_back(CHAR_START);
      end
    end
    if (it.has_byte) begin
      bytes_out.push_back(it.payload_byte);
      pkt_sum = pkt_sum + it.payload_byte;
    end
    if (it.last_item && it.add_end) begin
      bytes_out.push_back(CHAR_END);
      bytes_out.push_back(ascii_hex(pkt_sum[7:4]));
      bytes_out.push_back(ascii_hex(pkt_sum[3:0]));
    end
    foreach (bytes_out[i]) begin
      bt.out_byte      = bytes_out[i];
      bt.end_of_run    = (i == bytes_out.size() - 1);
      bt.end_of_packet = bt.end_of_run && it.last_item;
      pending_beats.push_back(bt);
    end
    return bytes_out.size();
  endfunction

  function automatic payload_item_t item_of(input logic [7:0] b, input logic h,
                                            input logic f, input logic l,
                                            input logic s, input logic e);
    payload_item_t it;
    it.payload_byte = b;
    it.has_byte     = h;
    it.first_item   = f;
    it.last_item    = l;
    it.add_start    = s;
    it.add_end      = e;
    return it;
  endfunction

  // Offer one item, with random gaps, and predict it once accepted
  task automatic send_item(input payload_item_t it);
    while (idle_on && $urandom_range(99) < 21) begin
      item_ch.valid        <= 1'b0;
      item_ch.payload_byte <= 8'($urandom);
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.payload_byte <= it.payload_byte;
    item_ch.has_byte     <= it.has_byte;
    item_ch.first_item   <= it.first_item;
    item_ch.last_item    <= it.last_item;
    item_ch.add_start    <= it.add_start;
    item_ch.add_end      <= it.add_end;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (frame_item(it) > 0) framed_items++;
  endtask

  // Stop offering and wait until every predicted beat has come out
  task automatic settle_outputs();
    item_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_no_ack(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ack_off   = v;
  endtask

  // Full frames, byte extremes, empty packet, checksum wrap
  task automatic test_framing_basics();
    send_item(item_of(8'h00, 1, 1, 1, 1, 1));
    send_item(item_of(8'hff, 1, 1, 1, 1, 1));
    send_item(item_of(8'ha5, 0, 1, 1, 1, 1));
    // start flag off the first item and end flag off the last are ignored
    send_item(item_of(8'h80, 1, 1, 0, 1, 0));
    send_item(item_of(8'h7f, 1, 0, 0, 1, 1));
    send_item(item_of(8'h9a, 1, 0, 1, 0, 1));
    settle_outputs();
  endtask

  task automatic test_special_cases();
    // no start framing: bare payload, then suffix
    send_item(item_of(8'h3c, 1, 1, 0, 0, 0));
    send_item(item_of(8'hc3, 1, 0, 1, 0, 1));
    // items that produce nothing at all
    send_item(item_of(8'h55, 0, 0, 0, 1, 1));
    send_item(item_of(8'haa, 0, 0, 1, 0, 0));
    // first item with no output still clears the sum
    send_item(item_of(8'h11, 0, 1, 0, 0, 0));
    // bytes with no first item keep summing
    send_item(item_of(8'h12, 1, 0, 0, 0, 0));
    send_item(item_of(8'h34, 1, 0, 1, 0, 1));
    send_item(item_of(8'hde, 1, 0, 0, 0, 0));
    send_item(item_of(8'h00, 0, 0, 1, 1, 1));
    settle_outputs();
  endtask

  task automatic test_skip_ack();
    set_no_ack(1'b1);
    send_item(item_of(8'h5a, 1, 1, 1, 1, 1));
    send_item(item_of(8'h00, 0, 1, 1, 1, 1));
    send_item(item_of(8'hb7, 1, 1, 0, 1, 1));
    send_item(item_of(8'h4e, 1, 0, 1, 1, 1));
    settle_outputs();
    set_no_ack(1'b0);
  endtask

  // Mostly well-formed packets with random content, some noise items
  task automatic test_random_packets(input int count, input logic ack_setting,
                                     input bit gaps);
    int            goal;
    int            len;
    payload_item_t it;
    goal    = framed_items + count;
    idle_on = gaps;
    set_no_ack(ack_setting);
    while (framed_items < goal) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(1, 7);
        for (int k = 0; k < len; k++) begin
          it.payload_byte = 8'($urandom);
          it.has_byte     = (len == 1) ? ($urandom_range(3) != 0)
                                       : ($urandom_range(99) < 93);
          it.first_item   = (k == 0);
          it.last_item    = (k == len - 1);
          it.add_start    = ($urandom_range(99) < 85);
          it.add_end      = ($urandom_range(99) < 85);
          send_item(it);
        end
      end else begin
        it = payload_item_t'($urandom_range(0, 8191));
        send_item(it);
      end
    end
    settle_outputs();
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    byte_ch.ready <= idle_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  // Compare each framed beat against the oldest prediction
  always @(posedge clk) begin
    framed_beat_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_byte %h", byte_ch.out_byte);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (byte_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, byte_ch.out_byte);
          errors++;
        end
        if (byte_ch.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %b, got %b", want.end_of_run,
                 byte_ch.end_of_run);
          errors++;
        end
        if (byte_ch.end_of_packet !== want.end_of_packet) begin
          $error("end_of_packet: expected %b, got %b", want.end_of_packet,
                 byte_ch.end_of_packet);
          errors++;
        end
      end
    end
  end

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    item_ch.valid        = 1'b0;
    item_ch.payload_byte = 8'h00;
    item_ch.has_byte     = 1'b0;
    item_ch.first_item   = 1'b0;
    item_ch.last_item    = 1'b0;
    item_ch.add_start    = 1'b0;
    item_ch.add_end      = 1'b0;
    byte_ch.ready        = 1'b0;
    ack_off              = 1'b0;
    pkt_sum              = 8'd0;
    framed_items         = 0;
    errors               = 0;
    idle_on              = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_framing_basics();
    test_special_cases();
    test_skip_ack();
    test_random_packets(37, 1'b0, 1'b1);
    test_random_packets(33, 1'b1, 1'b0);
    test_random_packets(37, 1'($urandom_range(1)), 1'b1);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
